### src/bchd_pkg.sv
// Package for the button click and hold decoder.
// Holds the shared constants, the register indexes, the result record and the tick-timer helper.
// Depends on nothing.
package bchd_pkg;

    localparam int DEBOUNCE_SAMPLES_DEF = 8;
    localparam int MAX_CLICKS_DEF       = 8;

    // Timer layout: the top bit marks a running timer and the low seven bits count ticks.
    localparam logic [7:0]  RUN_BIT  = 8'h80;
    localparam logic [6:0]  CNT_MASK = 7'h7F;
    localparam logic [15:0] DB_SEED  = 16'h00AA;

    localparam int CFG_W  = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_LONG_PRESS     = 2'd0;
    localparam logic [1:0] REG_TACTICAL_PRESS = 2'd1;
    localparam logic [1:0] REG_CLICK_WINDOW   = 2'd2;

    localparam logic [6:0] LONG_PRESS_RST     = 7'd5;
    localparam logic [6:0] TACTICAL_PRESS_RST = 7'd2;
    localparam logic [6:0] CLICK_WINDOW_RST   = 7'd4;

    typedef struct packed {
        logic       event_pending;
        logic [3:0] click_count;
        logic       long_press_event;
        logic [3:0] click_hold_count;
        logic       hold_active;
        logic       key_down;
    } result_t;

    // Advances a running timer by one tick, saturating at the limit.
    function automatic logic [7:0] tick_timer(input logic [7:0] t, input logic [6:0] limit);
        logic [6:0] c;
        begin
            c = t[6:0];
            if (!t[7])
            begin
                tick_timer = t;
            end
            else
            begin
                if (c < limit)
                begin
                    c = c + 7'd1;
                end
                tick_timer = RUN_BIT | {1'b0, c & CNT_MASK};
            end
        end
    endfunction

endpackage

### src/button_click_hold_decoder_top.sv
// Top level of the button click and hold decoder.
// Holds the decode logic, the configuration registers and the output buffering.
// Depends on bchd_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------------------
//  input    | in_valid / in_stall  | raw_level, timer_tick, tactical_mode, ack_long,
//           |                      | ack_short
//  output   | out_valid / out_stall| event_pending, click_count, long_press_event,
//           |                      | click_hold_count, hold_active, key_down
//  config   | APB write, pready=1  | long_press_ticks, tactical_long_press_ticks,
//           |                      | click_window_ticks at byte addresses 0, 4 and 8
//
// One request is taken per cycle while in_stall is low, and its result is registered.
// The decoder state is updated in a single pass of logic at the edge that accepts the request.
// Reset clears the state to the released, armed condition and loads the register defaults.
// A stalled result is held in the output register and a second result goes into a skid
// register, so the input stalls only once both are full.
module button_click_hold_decoder_top #(
    parameter int DEBOUNCE_SAMPLES = bchd_pkg::DEBOUNCE_SAMPLES_DEF,
    parameter int MAX_CLICKS       = bchd_pkg::MAX_CLICKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        raw_level,
    input  logic                        timer_tick,
    input  logic                        tactical_mode,
    input  logic                        ack_long,
    input  logic                        ack_short,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        event_pending,
    output logic [3:0]                  click_count,
    output logic                        long_press_event,
    output logic [3:0]                  click_hold_count,
    output logic                        hold_active,
    output logic                        key_down,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bchd_pkg::ADDR_W-1:0] paddr,
    input  logic [bchd_pkg::DATA_W-1:0] pwdata,
    output logic [bchd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int DB_W = DEBOUNCE_SAMPLES;
    // Hold status holds k+1 for k clicks, so it needs room for MAX_CLICKS+1.
    localparam int HS_W = $clog2(MAX_CLICKS + 2);

    // Configuration registers.
    logic [6:0] long_press_reg;
    logic [6:0] tactical_press_reg;
    logic [6:0] click_window_reg;

    // Decoder state.
    logic [7:0]      press_timer_reg,  press_timer_next;
    logic [7:0]      window_timer_reg, window_timer_next;
    logic [DB_W-1:0] debounce_reg,     debounce_next;
    logic            armed_reg,        armed_next;
    logic            expect_rel_reg,   expect_rel_next;
    logic            pressed_reg,      pressed_next;
    logic [3:0]      short_count_reg,  short_count_next;
    logic            short_event_reg,  short_event_next;
    logic            hold_det_reg,     hold_det_next;
    logic [HS_W-1:0] hold_status_reg,  hold_status_next;

    // Output buffering.
    bchd_pkg::result_t out_data_reg, skid_data_reg, result_new;
    logic              out_valid_reg, skid_valid_reg;

    logic       accept;
    logic       out_take;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [6:0] limit;
    logic       fire;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[3:2];

    // The registers are to be written only while the decoder is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg     <= bchd_pkg::LONG_PRESS_RST;
            tactical_press_reg <= bchd_pkg::TACTICAL_PRESS_RST;
            click_window_reg   <= bchd_pkg::CLICK_WINDOW_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bchd_pkg::REG_LONG_PRESS:     long_press_reg     <= pwdata[6:0];
                bchd_pkg::REG_TACTICAL_PRESS: tactical_press_reg <= pwdata[6:0];
                bchd_pkg::REG_CLICK_WINDOW:   click_window_reg   <= pwdata[6:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            bchd_pkg::REG_LONG_PRESS:     prdata = {25'd0, long_press_reg};
            bchd_pkg::REG_TACTICAL_PRESS: prdata = {25'd0, tactical_press_reg};
            bchd_pkg::REG_CLICK_WINDOW:   prdata = {25'd0, click_window_reg};
            default:                      prdata = '0;
        endcase
    end

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign out_take = out_valid_reg & ~out_stall;
    assign limit    = tactical_mode ? tactical_press_reg : long_press_reg;
    assign fire     = armed_reg & (expect_rel_reg ? raw_level : ~raw_level);

    // Next state for one sample, in the order: acknowledges, edge detector, tick,
    // debounce, then the hold and click window decisions.
    always_comb
    begin
        press_timer_next  = press_timer_reg;
        window_timer_next = window_timer_reg;
        debounce_next     = debounce_reg;
        armed_next        = armed_reg;
        expect_rel_next   = expect_rel_reg;
        pressed_next      = pressed_reg;
        short_count_next  = short_count_reg;
        short_event_next  = short_event_reg;
        hold_det_next     = hold_det_reg;
        hold_status_next  = hold_status_reg;

        if (ack_long && hold_status_next == HS_W'(1))
        begin
            hold_status_next = '0;
        end
        if (ack_short && short_event_next && short_count_next != 4'd0)
        begin
            short_event_next = 1'b0;
            short_count_next = 4'd0;
        end

        if (fire)
        begin
            if (expect_rel_reg)
            begin
                // Release: a hold in progress or pending is cleared, otherwise a short
                // press adds a click and restarts the window.
                pressed_next     = 1'b0;
                press_timer_next = 8'd0;
                if (hold_det_next || hold_status_next != '0)
                begin
                    hold_status_next = '0;
                    hold_det_next    = 1'b0;
                end
                else if (press_timer_reg[6:0] < long_press_reg)
                begin
                    if (short_count_next < 4'(MAX_CLICKS))
                    begin
                        short_count_next = short_count_next + 4'd1;
                    end
                    window_timer_next = bchd_pkg::RUN_BIT;
                end
            end
            else
            begin
                pressed_next = 1'b1;
                if (window_timer_next[7])
                begin
                    window_timer_next = bchd_pkg::RUN_BIT;
                end
                if (!press_timer_next[7])
                begin
                    press_timer_next = bchd_pkg::RUN_BIT;
                end
            end
            armed_next    = 1'b0;
            debounce_next = DB_W'(bchd_pkg::DB_SEED);
        end

        if (timer_tick)
        begin
            press_timer_next  = bchd_pkg::tick_timer(press_timer_next, limit);
            window_timer_next = bchd_pkg::tick_timer(window_timer_next, click_window_reg);
        end

        if (!armed_next)
        begin
            debounce_next = {debounce_next[DB_W-2:0], raw_level};
            if (debounce_next == '1 || debounce_next == '0)
            begin
                pressed_next    = ~debounce_next[0];
                expect_rel_next = ~debounce_next[0];
                armed_next      = 1'b1;
            end
        end

        if (pressed_next && window_timer_next[7])
        begin
            window_timer_next = bchd_pkg::RUN_BIT;
        end

        if (pressed_next && press_timer_next == {1'b1, limit})
        begin
            if (short_count_next != 4'd0)
            begin
                window_timer_next = 8'd0;
                short_event_next  = 1'b0;
                hold_det_next     = 1'b0;
                hold_status_next  = HS_W'({1'b0, short_count_next} + 5'd1);
                short_count_next  = 4'd0;
            end
            else
            begin
                short_count_next = 4'd0;
                hold_status_next = HS_W'(1);
                hold_det_next    = 1'b1;
            end
            press_timer_next = 8'd0;
        end

        if (!pressed_next && window_timer_next == {1'b1, click_window_reg})
        begin
            window_timer_next = 8'd0;
            if (!hold_det_next)
            begin
                short_event_next = 1'b1;
            end
            else
            begin
                hold_det_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result_new.event_pending    = (hold_status_next != '0) | short_event_next;
        result_new.click_count      = (hold_status_next != '0 || !short_event_next) ?
                                      4'd0 : short_count_next;
        result_new.long_press_event = (hold_status_next == HS_W'(1));
        result_new.click_hold_count = (hold_status_next > HS_W'(1)) ?
                                      4'(hold_status_next - HS_W'(1)) : 4'd0;
        result_new.hold_active      = hold_det_next;
        result_new.key_down         = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_timer_reg  <= 8'd0;
            window_timer_reg <= 8'd0;
            debounce_reg     <= '1;
            armed_reg        <= 1'b1;
            expect_rel_reg   <= 1'b0;
            pressed_reg      <= 1'b0;
            short_count_reg  <= 4'd0;
            short_event_reg  <= 1'b0;
            hold_det_reg     <= 1'b0;
            hold_status_reg  <= '0;
        end
        else if (accept)
        begin
            press_timer_reg  <= press_timer_next;
            window_timer_reg <= window_timer_next;
            debounce_reg     <= debounce_next;
            armed_reg        <= armed_next;
            expect_rel_reg   <= expect_rel_next;
            pressed_reg      <= pressed_next;
            short_count_reg  <= short_count_next;
            short_event_reg  <= short_event_next;
            hold_det_reg     <= hold_det_next;
            hold_status_reg  <= hold_status_next;
        end
    end

    // Valid flags of the output register and the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg  <= skid_valid_reg | accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= result_new;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result_new;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_pending    = out_data_reg.event_pending;
    assign click_count      = out_data_reg.click_count;
    assign long_press_event = out_data_reg.long_press_event;
    assign click_hold_count = out_data_reg.click_hold_count;
    assign hold_active      = out_data_reg.hold_active;
    assign key_down         = out_data_reg.key_down;

endmodule
